[src/assert_macros.svh]
// Assertion macros shared by the sequencer modules.
// Depends on nothing; the checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/clws_pkg.sv]
// Types and constants of the character-LCD write sequencer.
// Depends on nothing; used by the front, back and top-level modules.
package clws_pkg;

    // Request kinds.
    localparam logic [2:0] KIND_CMD   = 3'd0;
    localparam logic [2:0] KIND_DATA  = 3'd1;
    localparam logic [2:0] KIND_GOTO  = 3'd2;
    localparam logic [2:0] KIND_INIT  = 3'd3;
    localparam logic [2:0] KIND_NUM   = 3'd4;
    localparam logic [2:0] KIND_GLYPH = 3'd5;

    // Controller command bytes and character constants.
    localparam logic [7:0] ROW1_OFFSET     = 8'h40;
    localparam logic [7:0] INIT_FUNC_SET   = 8'h38;
    localparam logic [7:0] INIT_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] INIT_CLEAR      = 8'h01;
    localparam logic [7:0] INIT_NIB_A      = 8'h02;
    localparam logic [7:0] INIT_NIB_B      = 8'h08;
    localparam logic [7:0] SET_DDRAM       = 8'h80;
    localparam logic [7:0] SET_CGRAM       = 8'h40;
    localparam logic [7:0] ASCII_ZERO      = 8'h30;

    // One request transaction.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [31:0] number_value;
        logic [5:0]  column;
        logic [1:0]  line;
        logic [2:0]  glyph_slot;
        logic [63:0] glyph_rows;
    } t_req;

    // One result transaction.
    typedef struct packed {
        logic       strobe_res;
        logic       reg_select;
        logic [7:0] bus_value;
        logic       power_up_wait;
        logic       error;
        logic       last;
    } t_res;

    // One byte operation passed from the front to the back.
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       pwr_wait;
        logic       last;
        logic       err;
        logic       single;
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_front_state;

endpackage

[src/char_lcd_write_sequencer.sv]
// Top level of the character-LCD write sequencer: configuration register and queues.
// Depends on clws_pkg, clws_fifo, clws_front and clws_back.
//
// Each request becomes a run of controller bus strobes, delivered one per cycle
// from the result queue while it is popped: one per byte in eight-bit mode, two
// per byte (high nibble, then low) in four-bit mode, up to 22 for a custom glyph.
// The front stage registers a request, then issues one byte operation per cycle
// while the op queue has room; a number first passes the shift-and-add decimal
// converter, then ten digit positions. A new request is taken once the front has
// issued the last operation of the previous one, while the back stage is still
// draining it. Unknown kinds are dropped without a result. The user must write
// the bus mode register only while idle; the block does not enforce this.
module char_lcd_write_sequencer
    import clws_pkg::*;
#(
    parameter int OP_DEPTH  = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    input  t_req i_req,
    output logic full,
    output logic empty,
    input  logic pop,
    output t_res o_res,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    logic r_four_bit;
    t_op  front_op;
    logic front_push;
    logic op_full;
    t_op  back_op;
    logic op_empty;
    logic op_pop;
    logic res_push;
    t_res back_res;
    logic res_full;

    // Bus mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit <= 1'b0;
        end else if (i_cfg_we) begin
            r_four_bit <= i_cfg_wdata;
        end
    end

    clws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_four_bit (r_four_bit),
        .i_push     (push),
        .i_req      (i_req),
        .o_full     (full),
        .o_op_push  (front_push),
        .o_op       (front_op),
        .i_op_full  (op_full)
    );

    clws_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (OP_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_op),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_data  (back_op),
        .o_empty (op_empty)
    );

    clws_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_four_bit (r_four_bit),
        .i_op       (back_op),
        .i_op_valid (!op_empty),
        .o_op_pop   (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (back_res)
    );

    clws_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_res),
        .o_empty (empty)
    );

endmodule

[src/clws_fifo.sv]
// Small first-in first-out queue of packed words, used between the stages.
// Depends on nothing.
module clws_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage is written at the write pointer.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/clws_front.sv]
// Front stage: accepts requests, converts numbers to decimal and issues byte operations.
// Depends on clws_pkg and assert_macros.svh.
`include "assert_macros.svh"
module clws_front
    import clws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_four_bit,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    output logic o_op_push,
    output t_op  o_op,
    input  logic i_op_full
);

    t_front_state r_state, n_state;
    t_req         r_req;
    logic [3:0]   r_idx, n_idx;
    logic [4:0]   r_cnt, n_cnt;
    logic [39:0]  r_bcd, n_bcd;
    logic [31:0]  r_bin, n_bin;
    logic [63:0]  r_rows, n_rows;
    logic         r_started, n_started;

    t_op          op;
    logic         op_valid;
    logic         skip;
    logic         advance;
    logic [3:0]   digit;
    logic [7:0]   ddram;
    logic         bad_line;
    logic [39:0]  bcd_adj;

    assign o_full    = (r_state != ST_IDLE);
    assign o_op_push = op_valid;
    assign o_op      = op;
    assign digit     = r_bcd[{r_idx, 2'b00} +: 4];
    assign bad_line  = (r_req.line > 2'd1);
    assign ddram     = ({2'b00, r_req.column} | ((r_req.line == 2'd1) ? ROW1_OFFSET : 8'h00))
                       | SET_DDRAM;

    // Double-dabble correction: each digit of five or more gets three added.
    always_comb begin
        for (int d = 0; d < 10; d++) begin
            bcd_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                           : r_bcd[d*4 +: 4];
        end
    end

    // Byte operation for the current step of the request.
    always_comb begin
        op       = '0;
        op_valid = 1'b0;
        skip     = 1'b0;
        if (r_state == ST_EMIT) begin
            op_valid = 1'b1;
            unique case (r_req.kind)
                KIND_CMD: begin
                    op.data = r_req.byte_value;
                    op.last = 1'b1;
                end
                KIND_DATA: begin
                    op.rs   = 1'b1;
                    op.data = r_req.byte_value;
                    op.last = 1'b1;
                end
                KIND_GOTO: begin
                    op.err  = bad_line;
                    op.data = bad_line ? 8'h00 : ddram;
                    op.last = 1'b1;
                end
                KIND_INIT: begin
                    if (i_four_bit) begin
                        case (r_idx)
                            4'd0: begin
                                op.data     = INIT_NIB_A;
                                op.single   = 1'b1;
                                op.pwr_wait = 1'b1;
                            end
                            4'd1: begin
                                op.data   = INIT_NIB_A;
                                op.single = 1'b1;
                            end
                            4'd2: begin
                                op.data   = INIT_NIB_B;
                                op.single = 1'b1;
                            end
                            4'd3: op.data = INIT_DISPLAY_ON;
                            default: begin
                                op.data = INIT_CLEAR;
                                op.last = 1'b1;
                            end
                        endcase
                    end else begin
                        case (r_idx)
                            4'd0: begin
                                op.data     = INIT_FUNC_SET;
                                op.pwr_wait = 1'b1;
                            end
                            4'd1: op.data = INIT_DISPLAY_ON;
                            default: begin
                                op.data = INIT_CLEAR;
                                op.last = 1'b1;
                            end
                        endcase
                    end
                end
                KIND_NUM: begin
                    // Leading zero digits are passed over without an operation.
                    if (digit == 4'd0 && !r_started && r_idx != 4'd0) begin
                        skip     = 1'b1;
                        op_valid = 1'b0;
                    end else begin
                        op.rs   = 1'b1;
                        op.data = ASCII_ZERO | {4'h0, digit};
                        op.last = (r_idx == 4'd0);
                    end
                end
                KIND_GLYPH: begin
                    if (bad_line) begin
                        op.err  = 1'b1;
                        op.last = 1'b1;
                    end else begin
                        case (r_idx)
                            4'd0: op.data = SET_CGRAM | {2'b00, r_req.glyph_slot, 3'b000};
                            4'd9: op.data = ddram;
                            4'd10: begin
                                op.rs   = 1'b1;
                                op.data = {5'b00000, r_req.glyph_slot};
                                op.last = 1'b1;
                            end
                            default: begin
                                op.rs   = 1'b1;
                                op.data = r_rows[7:0];
                            end
                        endcase
                    end
                end
                default: op_valid = 1'b0;
            endcase
        end
    end

    assign advance = skip || (op_valid && !i_op_full);

    // Next state and step registers.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_bcd     = r_bcd;
        n_bin     = r_bin;
        n_rows    = r_rows;
        n_started = r_started;
        unique case (r_state)
            ST_IDLE: begin
                n_idx     = '0;
                n_cnt     = '0;
                n_bcd     = '0;
                n_bin     = i_req.number_value;
                n_rows    = i_req.glyph_rows;
                n_started = 1'b0;
                if (i_push) begin
                    case (i_req.kind) inside
                        KIND_NUM: n_state = ST_CONV;
                        KIND_CMD, KIND_DATA, KIND_GOTO, KIND_INIT, KIND_GLYPH:
                            n_state = ST_EMIT;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: begin
                // One binary bit enters the decimal digits per cycle.
                n_bcd = {bcd_adj[38:0], r_bin[31]};
                n_bin = {r_bin[30:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_state = ST_EMIT;
                    n_idx   = 4'd9;
                end
            end
            ST_EMIT: begin
                if (advance) begin
                    if (r_req.kind == KIND_NUM) begin
                        n_idx = r_idx - 1'b1;
                        if (!skip) begin
                            n_started = 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                    if (r_req.kind == KIND_GLYPH && r_idx != 4'd0) begin
                        n_rows = {8'h00, r_rows[63:8]};
                    end
                    if (op_valid && op.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request and work registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_push) begin
            r_req <= i_req;
        end
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_bcd     <= n_bcd;
        r_bin     <= n_bin;
        r_rows    <= n_rows;
        r_started <= n_started;
    end

    `ASSERT_IMPLIES(a_digit_decimal, i_clk, i_rst_n,
        r_state == ST_EMIT && r_req.kind == KIND_NUM, digit <= 4'd9,
        "Number conversion left a digit above nine.")
    `ASSERT_NEXT(a_conv_done, i_clk, i_rst_n,
        r_state == ST_CONV && r_cnt == 5'd31, r_state == ST_EMIT && r_idx == 4'd9,
        "Conversion did not hand over at the top digit.")
    `ASSERT_NEXT(a_unknown_kind, i_clk, i_rst_n,
        r_state == ST_IDLE && i_push && i_req.kind > KIND_GLYPH, r_state == ST_IDLE,
        "An unknown request kind started work.")

endmodule

[src/clws_back.sv]
// Back stage: turns byte operations into bus strobes, split into nibbles in four-bit mode.
// Depends on clws_pkg and assert_macros.svh.
`include "assert_macros.svh"
module clws_back
    import clws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_four_bit,
    input  t_op  i_op,
    input  logic i_op_valid,
    output logic o_op_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    logic r_phase, n_phase;
    logic split;
    logic done;

    assign split      = i_four_bit && !i_op.single && !i_op.err;
    assign o_res_push = i_op_valid;
    assign done       = i_op_valid && !i_res_full;
    assign o_op_pop   = done && (!split || r_phase);

    // Result fields for the current operation and nibble phase.
    always_comb begin
        o_res = '0;
        if (i_op.err) begin
            o_res.error = 1'b1;
            o_res.last  = 1'b1;
        end else begin
            o_res.strobe_res    = 1'b1;
            o_res.reg_select    = i_op.rs;
            o_res.bus_value     = !split ? i_op.data
                                : (r_phase ? {4'h0, i_op.data[3:0]} : {4'h0, i_op.data[7:4]});
            o_res.power_up_wait = i_op.pwr_wait && (!split || !r_phase);
            o_res.last          = i_op.last && (!split || r_phase);
        end
    end

    // The phase flips on each nibble transaction of a split byte.
    always_comb begin
        n_phase = r_phase;
        if (done && split) begin
            n_phase = !r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

    `ASSERT_IMPLIES(a_phase_holds_op, i_clk, i_rst_n, r_phase, i_op_valid && split, "Low nibble pending without its operation.")
    `ASSERT_IMPLIES(a_last_on_low, i_clk, i_rst_n, o_res_push && o_res.last && split, r_phase, "Last marked on a high nibble.")

endmodule
